// ----- hw/rtl/rhb_pkg.sv -----
`default_nettype none
package rhb_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CAP = (STORE_DEPTH < MAX_RESULTS) ? STORE_DEPTH : MAX_RESULTS;
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W = 5;

  localparam int HANDLE_W = 16;
  localparam int DRAW_W = 16;
  localparam int THR_W = 17;
  localparam int DLY_W = 8;
  localparam int TOTAL_W = 32;
  localparam int OP_W = 2;
  localparam int KIND_W = 2;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 56;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_DECIDE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic                hit;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rhb_front.sv -----
`default_nettype none
module rhb_front
  import rhb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [OP_W-1:0]       in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd,
  output logic [DLY_W-1:0]           hold_delay
);

  logic [THR_W-1:0] thr_r;
  logic [DLY_W-1:0] dly_r;
  logic [DRAW_W-1:0] draw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      dly_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_wdata[THR_W-1:0];
        REG_DELAY:     dly_r <= cfg_wdata[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  assign draw       = in_tdata[HANDLE_W +: DRAW_W];
  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full;
  assign hold_delay = dly_r;

  always_comb begin
    q_cmd.op     = in_tuser;
    q_cmd.handle = in_tdata[HANDLE_W-1:0];
    q_cmd.hit    = (thr_r != '0) && (dly_r != '0) && ({1'b0, draw} < thr_r);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rhb_queue.sv -----
`default_nettype none
module rhb_queue
  import rhb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rhb_exec.sv -----
`default_nettype none
module rhb_exec
  import rhb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [DLY_W-1:0]       hold_delay,
  input  wire logic                   q_valid,
  input  wire cmd_t                   q_head,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,
  output logic [KIND_W-1:0]           out_tuser,
  output logic                        out_tlast
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    keep_r, keep_nxt;
  logic [CNT_W-1:0]    rel_r, rel_nxt;
  logic [CNT_W-1:0]    emit_r, emit_nxt;

  logic [HANDLE_W-1:0] hnd_r [CAP];
  logic [DLY_W-1:0]    tk_r [CAP];

  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [HANDLE_W-1:0] wr_h;
  logic [DLY_W-1:0]    wr_t;

  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_held_r, out_held_nxt;
  logic                out_last_r, out_last_nxt;
  logic [CNT_W-1:0]    out_occ_r, out_occ_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic                out_free;
  logic                emit;
  logic [CNT_W-1:0]    rel_cnt;
  logic                at_end;
  logic [DLY_W-1:0]    cur_t;
  logic                cur_rls;
  logic                take;

  assign out_free = !out_valid_r || out_tready;
  assign at_end   = (CNT_W'(idx_r) == cnt_r - CNT_W'(1));
  assign cur_t    = tk_r[idx_r];
  assign cur_rls  = (cur_t <= DLY_W'(1));
  assign take     = q_head.hit && (cnt_r < CNT_W'(CAP));

  // entries released on the next tick
  always_comb begin
    rel_cnt = '0;
    for (int k = 0; k < CAP; k++) begin
      if (CNT_W'(k) < cnt_r && tk_r[k] <= DLY_W'(1)) rel_cnt = rel_cnt + 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    rel_nxt        = rel_r;
    emit_nxt       = emit_r;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    wr_idx         = keep_r;
    wr_h           = hnd_r[idx_r];
    wr_t           = cur_t - DLY_W'(1);
    emit           = 1'b0;
    out_kind_nxt   = KIND_NONE;
    out_handle_nxt = '0;
    out_held_nxt   = 1'b0;
    out_last_nxt   = 1'b1;
    out_occ_nxt    = cnt_r;
    out_total_nxt  = total_r;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          case (q_head.op)
            OP_OFFER: begin
              out_kind_nxt   = KIND_DECIDE;
              out_handle_nxt = q_head.handle;
              out_held_nxt   = take;
              if (take) begin
                wr_en     = 1'b1;
                wr_idx    = cnt_r[IDX_W-1:0];
                wr_h      = q_head.handle;
                wr_t      = hold_delay;
                cnt_nxt   = cnt_r + 1'b1;
                total_nxt = total_r + 1'b1;
              end
              out_occ_nxt   = cnt_nxt;
              out_total_nxt = total_nxt;
            end
            OP_TICK: begin
              if (cnt_r != '0) begin
                emit      = (rel_cnt == '0);
                state_nxt = ST_TICK;
                idx_nxt   = '0;
                keep_nxt  = '0;
                emit_nxt  = '0;
                rel_nxt   = rel_cnt;
              end
            end
            OP_FLUSH: begin
              if (cnt_r != '0) begin
                emit      = 1'b0;
                state_nxt = ST_FLUSH;
                idx_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK: begin
        if (!cur_rls || out_free) begin
          if (cur_rls) begin
            emit           = 1'b1;
            out_kind_nxt   = KIND_RELEASE;
            out_handle_nxt = hnd_r[idx_r];
            out_last_nxt   = (emit_r + 1'b1 == rel_r);
            out_occ_nxt    = cnt_r - rel_r;
            emit_nxt       = emit_r + 1'b1;
          end else begin
            wr_en    = 1'b1;
            keep_nxt = keep_r + 1'b1;
          end
          if (at_end) begin
            cnt_nxt   = cnt_r - rel_r;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit           = 1'b1;
          out_kind_nxt   = KIND_RELEASE;
          out_handle_nxt = hnd_r[idx_r];
          out_last_nxt   = at_end;
          out_occ_nxt    = '0;
          if (at_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hnd_r[wr_idx] <= wr_h;
      tk_r[wr_idx]  <= wr_t;
    end
    if (emit) begin
      out_kind_r   <= out_kind_nxt;
      out_handle_r <= out_handle_nxt;
      out_held_r   <= out_held_nxt;
      out_last_r   <= out_last_nxt;
      out_occ_r    <= out_occ_nxt;
      out_total_r  <= out_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      rel_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      rel_r       <= rel_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_total_r, out_occ_r, out_held_r, out_handle_r};

endmodule
`default_nettype wire

// ----- hw/rtl/reorder_hold_buffer.sv -----
// Offer or unused code: the item passes the command queue, then the output register.
// Tick or flush: back end walks the N held entries one per cycle, pausing on a release
// until the output is free; the first release is registered from the walk state.
// A 2-entry command queue lets input items be taken while the back end walks the store.
// Reset (rst_n low, synchronous) empties the store, queue and output register,
// zeroes the hold total and both config registers; stored entries are not cleared.
`default_nettype none
module reorder_hold_buffer
  import rhb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // packet_handle, rand_draw
  input  wire logic [OP_W-1:0]       in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // out_handle, was_held, occupancy,
                                                 // reordered_total, zero pad
  output logic [KIND_W-1:0]          out_tuser,  // result_kind
  output logic                       out_tlast
);

  cmd_t             push_cmd;
  cmd_t             head;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic [DLY_W-1:0] hold_delay;

  rhb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .hold_delay (hold_delay)
  );

  rhb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head)
  );

  rhb_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_delay (hold_delay),
    .q_valid    (q_valid),
    .q_head     (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- test/tb_reorder_hold_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_reorder_hold_buffer;
  import rhb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [DRAW_W-1:0]   draw;
  } req_t;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic                held;
    logic                last;
    logic [CNT_W-1:0]    occ;
    logic [TOTAL_W-1:0]  total;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic out_tlast;

  reorder_hold_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  req_t    req_backlog[$];
  result_t due_results[$];

  // shadow of the store and registers
  logic [HANDLE_W-1:0] sh_handle[CAP];
  logic [DLY_W-1:0]    sh_ticks[CAP];
  int                  sh_count = 0;
  logic [TOTAL_W-1:0]  sh_total = '0;
  logic [THR_W-1:0]    sh_thr = '0;
  logic [DLY_W-1:0]    sh_dly = '0;

  int  n_queued = 0;
  int  n_taken = 0;
  int  n_checked = 0;
  int  n_released = 0;
  int  n_held = 0;
  int  n_settings = 1;
  int  errors = 0;
  int  stall_cycles = 0;
  bit  in_fire = 1'b0;
  bit  calm = 1'b0;

  task automatic predict_outcome(input req_t r);
    result_t res[$];
    result_t one;
    int keep;
    logic [DLY_W-1:0] t;
    logic take;
    one = '{default: '0};
    case (r.op)
      OP_OFFER: begin
        take = (sh_thr != 0) && (sh_dly != 0) && (sh_count < CAP) &&
               ({1'b0, r.draw} < sh_thr);
        if (take) begin
          sh_handle[sh_count] = r.handle;
          sh_ticks[sh_count] = sh_dly;
          sh_count++;
          sh_total++;
          n_held++;
        end
        one.kind = KIND_DECIDE;
        one.handle = r.handle;
        one.held = take;
        res.insert(res.size(), one);
      end
      OP_TICK: begin
        keep = 0;
        for (int i = 0; i < sh_count; i++) begin
          t = sh_ticks[i];
          if (t != 0) t--;
          if (t == 0) begin
            one.kind = KIND_RELEASE;
            one.handle = sh_handle[i];
            res.insert(res.size(), one);
          end else begin
            sh_handle[keep] = sh_handle[i];
            sh_ticks[keep] = t;
            keep++;
          end
        end
        sh_count = keep;
      end
      OP_FLUSH: begin
        for (int i = 0; i < sh_count; i++) begin
          one.kind = KIND_RELEASE;
          one.handle = sh_handle[i];
          res.insert(res.size(), one);
        end
        sh_count = 0;
      end
      default: ;
    endcase
    if (res.size() == 0) begin
      one.kind = KIND_NONE;
      one.handle = '0;
      res.insert(res.size(), one);
    end
    foreach (res[k]) begin
      res[k].last = (k == res.size() - 1);
      res[k].occ = CNT_W'(sh_count);
      res[k].total = sh_total;
      due_results.insert(due_results.size(), res[k]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // input accept, prediction, result check, watchdog
  always @(posedge clk) begin
    result_t want;
    in_fire = in_tvalid && in_tready;
    if (rst_n) begin
      if (in_fire) begin
        predict_outcome('{op: in_tuser, handle: in_tdata[15:0], draw: in_tdata[31:16]});
        n_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got kind %0d handle %0h",
                     $time, out_tuser, out_tdata[15:0]);
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.kind, out_tuser);
          check_field("out_handle", want.handle, out_tdata[15:0]);
          check_field("was_held", want.held, out_tdata[16]);
          check_field("last", want.last, out_tlast);
          check_field("occupancy", want.occ, out_tdata[21:17]);
          check_field("reordered_total", want.total, out_tdata[53:22]);
          check_field("pad", 0, out_tdata[55:54]);
          if (want.kind == KIND_RELEASE) n_released++;
          n_checked++;
        end
      end
      if (in_fire || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time, due_results.size());
        $display("FAIL reorder_hold_buffer");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    req_t cur;
    if (in_tvalid && !in_fire) begin
    end else if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
      cur = req_backlog.pop_front();
      in_tuser <= cur.op;
      in_tdata <= {cur.draw, cur.handle};
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
  end

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h,
                           input logic [DRAW_W-1:0] d);
    req_t r;
    r.op = op;
    r.handle = h;
    r.draw = d;
    req_backlog.insert(req_backlog.size(), r);
    n_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) sh_thr = val;
    else sh_dly = val[DLY_W-1:0];
  endtask

  // a tick with no release still walks the store after its result leaves
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (n_taken != n_queued || due_results.size() != 0);
    repeat (CAP + 4) @(posedge clk);
  endtask

  task automatic random_reqs(input int count);
    int pick;
    logic [DRAW_W-1:0] d;
    logic [OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) op = OP_OFFER;
      else if (pick < 85) op = OP_TICK;
      else if (pick < 93) op = OP_FLUSH;
      else op = OP_NOP;
      case ($urandom_range(3))
        1: d = (sh_thr == 0) ? '0 : (sh_thr > 17'h10000 ? 16'hFFFF : DRAW_W'(sh_thr - 1));
        2: d = (sh_thr > 17'hFFFF) ? 16'hFFFF : sh_thr[15:0];
        default: d = DRAW_W'($urandom);
      endcase
      queue_req(op, HANDLE_W'($urandom), d);
    end
  endtask

  task automatic run_setting(input logic [CFG_DATA_W-1:0] thr,
                             input logic [DLY_W-1:0] dly, input int count);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_DELAY, dly);
    n_settings++;
    @(posedge clk);
    random_reqs(count);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset value: nothing held, empty tick and flush, unused code
    queue_req(OP_OFFER, 16'hFFFF, 16'h0000);
    queue_req(OP_NOP, 16'h1234, 16'h5678);
    queue_req(OP_TICK, 16'h0000, 16'h0000);
    queue_req(OP_FLUSH, 16'hFFFF, 16'hFFFF);
    settle();

    // threshold above range: fill the store, overflow, release all on one tick
    write_reg(REG_THRESHOLD, 17'h1FFFF);
    write_reg(REG_DELAY, 8'd3);
    n_settings++;
    @(posedge clk);
    queue_req(OP_OFFER, 16'h0000, 16'hFFFF);
    queue_req(OP_OFFER, 16'hFFFF, 16'h0000);
    for (int i = 2; i < 17; i++)
      queue_req(OP_OFFER, HANDLE_W'($urandom), DRAW_W'($urandom));
    repeat (3) queue_req(OP_TICK, HANDLE_W'($urandom), DRAW_W'($urandom));
    settle();

    calm = 1'b1;
    run_setting(17'h10000, 8'd1, 35);
    calm = 1'b0;
    run_setting(17'h08000, 8'd4, 40);
    run_setting(17'h00000, 8'd5, 20);
    run_setting(17'd20000, 8'd0, 20);
    run_setting(17'h00001, 8'd255, 30);
    run_setting(17'h1FFFF, 8'd2, 35);
    run_setting(17'd50000, 8'd6, 30);

    repeat (20) @(posedge clk);
    $display("Covered %0d items over %0d register settings: %0d results checked,",
             n_taken, n_settings, n_checked);
    $display("  %0d packets held, %0d released.", n_held, n_released);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS reorder_hold_buffer");
    end else begin
      $display("FAIL reorder_hold_buffer");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hw/rtl/rhb_pkg.sv
hw/rtl/rhb_front.sv
hw/rtl/rhb_queue.sv
hw/rtl/rhb_exec.sv
hw/rtl/reorder_hold_buffer.sv
test/tb_reorder_hold_buffer.sv
